[sv/oidd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package oidd_pkg;

  localparam int ArcW = 63;

  // content byte as it arrives
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_content;
  } byte_item_t;

  // one decoded arc
  typedef struct packed {
    logic [ArcW-1:0] arc_value;
    logic            last_arc;
    logic            error;
  } arc_item_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_ARC   = 2'd0,
    CMD_SPLIT = 2'd1,
    CMD_ERR   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [ArcW-1:0] value;
    logic            last;
  } cmd_t;

  // status of the command queue
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

[sv/oid_base128_arc_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Handshake             Payload
// byte_*      in         byte_valid/byte_stall  byte_item_t (content byte, end mark)
// arc_*       out        arc_valid/arc_stall    arc_item_t (arc, last, error)
//
// One content byte is taken per cycle unless byte_stall holds it; the shift-add in the front sets it.
// The first subidentifier leaves as two results.
// A result is registered in a two-entry queue, then in the output register, after its byte is taken.
// byte_stall rises only when the queue is full; arc_stall backs up into it.
// Synchronous reset clears decode state, empties the queue and clears the output valid.

module oid_base128_arc_decoder import oidd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire byte_item_t byte_item,
  output logic            arc_valid,
  input  wire logic       arc_stall,
  output arc_item_t       arc_item
);

  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;
  queue_status_t qstat;

  oidd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .qstat      (qstat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  oidd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  oidd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .arc_valid (arc_valid),
    .arc_stall (arc_stall),
    .arc_item  (arc_item)
  );

endmodule

`default_nettype wire

[sv/oidd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module oidd_front import oidd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire byte_item_t byte_item,
  input  wire queue_status_t qstat,
  output logic            push,
  output cmd_t            push_cmd
);

  logic [ArcW-1:0] accumulator;
  logic            first_arc_done;
  logic            skipping_after_error;

  logic            take;
  logic            more;
  logic            eoc;
  logic            overflow;
  logic            fault;
  logic [ArcW-1:0] shifted;

  // hold input while the queue has no room
  assign byte_stall = qstat.full;
  assign take       = byte_valid && !byte_stall;

  assign more     = byte_item.data_byte[7];
  assign eoc      = byte_item.end_of_content;
  assign overflow = |accumulator[ArcW-1:ArcW-7];
  assign fault    = overflow || (more && eoc);
  assign shifted  = {accumulator[ArcW-8:0], byte_item.data_byte[6:0]};

  // classify the byte into a queue command
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = CMD_ARC;
    push_cmd.value = shifted;
    push_cmd.last = eoc;
    if (take && !skipping_after_error) begin
      if (fault) begin
        push           = 1'b1;
        push_cmd.kind  = CMD_ERR;
        push_cmd.value = '0;
        push_cmd.last  = 1'b1;
      end else if (!more) begin
        push          = 1'b1;
        push_cmd.kind = first_arc_done ? CMD_ARC : CMD_SPLIT;
      end
    end
  end

  // advance the subidentifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator          <= '0;
      first_arc_done       <= 1'b0;
      skipping_after_error <= 1'b0;
    end else if (take) begin
      if (skipping_after_error) begin
        if (eoc) begin
          skipping_after_error <= 1'b0;
        end
      end else if (fault) begin
        accumulator          <= '0;
        first_arc_done       <= 1'b0;
        skipping_after_error <= !eoc;
      end else if (more) begin
        accumulator <= shifted;
      end else begin
        accumulator    <= '0;
        first_arc_done <= !eoc;
      end
    end
  end

endmodule

`default_nettype wire

[sv/oidd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module oidd_queue import oidd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output queue_status_t qstat
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head        = entry[rd_ptr];
  assign qstat.full  = count == 2'd2;
  assign qstat.empty = count == 2'd0;

  // store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/oidd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module oidd_back import oidd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire queue_status_t qstat,
  output logic      pop,
  output logic      arc_valid,
  input  wire logic arc_stall,
  output arc_item_t arc_item
);

  logic            second;
  logic            load;
  logic            lt80;
  logic            ge40;
  logic [ArcW-1:0] sub;
  logic [ArcW-1:0] rest;
  arc_item_t       item_next;

  assign load = !qstat.empty && (!arc_valid || !arc_stall);
  assign pop  = load && !(head.kind == CMD_SPLIT && !second);

  // split the first subidentifier into two arcs
  assign lt80 = head.value < ArcW'(80);
  assign ge40 = head.value >= ArcW'(40);
  assign sub  = lt80 ? (ge40 ? ArcW'(40) : '0) : ArcW'(80);
  assign rest = head.value - sub;

  // form the next result
  always_comb begin
    item_next.arc_value = head.value;
    item_next.last_arc  = head.last;
    item_next.error     = 1'b0;
    case (head.kind)
      CMD_ERR: begin
        item_next.arc_value = '0;
        item_next.last_arc  = 1'b1;
        item_next.error     = 1'b1;
      end
      CMD_SPLIT: begin
        if (!second) begin
          item_next.arc_value = lt80 ? {{(ArcW-1){1'b0}}, ge40} : ArcW'(2);
          item_next.last_arc  = 1'b0;
        end else begin
          item_next.arc_value = rest;
        end
      end
      default: begin
        item_next.arc_value = head.value;
      end
    endcase
  end

  // hold the output register until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      arc_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        arc_valid <= 1'b1;
        second    <= head.kind == CMD_SPLIT && !second;
      end else if (!arc_stall) begin
        arc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      arc_item <= item_next;
    end
  end

endmodule

`default_nettype wire

[sv/oidd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module oidd_checker import oidd_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       byte_valid,
  input wire logic       byte_stall,
  input wire logic       arc_valid,
  input wire logic       arc_stall,
  input wire arc_item_t  arc_item
);

  // an error result carries a zero arc and closes the identifier
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    arc_valid && arc_item.error |-> arc_item.arc_value == '0 && arc_item.last_arc)
    else $error("error result with nonzero arc or without last mark");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    arc_valid && arc_stall |=> arc_valid && $stable(arc_item))
    else $error("stalled result changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !arc_valid)
    else $error("result valid after reset");

  // the input stall only rises after a byte transfer
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    !byte_valid && !byte_stall |=> !byte_stall)
    else $error("input stall rose without a byte transfer");

endmodule

bind oid_base128_arc_decoder oidd_checker u_oidd_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .arc_valid  (arc_valid),
  .arc_stall  (arc_stall),
  .arc_item   (arc_item)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import oidd_pkg::*;

  localparam int TotalBytes = 500;
  localparam int WatchdogLimit = 2000;
  localparam int LongHold = 40;
  localparam int HoldAfterArcs = 60;
  localparam logic [ArcW-1:0] SubidCeiling = 63'd1 << 56;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_item_t byte_item = '0;
  logic       arc_valid;
  logic       arc_stall = 1'b0;
  arc_item_t  arc_item;

  // stimulus and scoreboard storage
  byte_item_t      byte_q[$];
  arc_item_t       arc_expect_q[$];
  int              bytes_queued = 0;
  int              mismatches = 0;
  int              arcs_seen = 0;
  int              send_gap = 0;
  int              stall_left = 0;
  int              idle_cycles = 0;
  logic            long_hold_done = 1'b0;
  logic            quiet = 1'b0;

  // decoder state mirror
  logic [ArcW-1:0] acc_sum = '0;
  logic            first_split_done = 1'b0;
  logic            skip_to_end = 1'b0;

  oid_base128_arc_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .arc_valid (arc_valid),
    .arc_stall (arc_stall),
    .arc_item  (arc_item)
  );

  always #1 clk = ~clk;

  function automatic void clear_decode();
    acc_sum = '0;
    first_split_done = 1'b0;
    skip_to_end = 1'b0;
  endfunction

  function automatic void expect_arc(logic [ArcW-1:0] val, logic fin, logic err);
    arc_expect_q.push_back(arc_item_t'{arc_value: val, last_arc: fin, error: err});
  endfunction

  // advance the mirrored decoder by one content byte and queue its arcs
  function automatic void decode_byte(byte_item_t it);
    logic [ArcW-1:0] v;
    if (skip_to_end) begin
      if (it.end_of_content)
        clear_decode();
      return;
    end
    if (acc_sum >= SubidCeiling || (it.data_byte[7] && it.end_of_content)) begin
      expect_arc('0, 1'b1, 1'b1);
      if (it.end_of_content) begin
        clear_decode();
      end else begin
        acc_sum = '0;
        skip_to_end = 1'b1;
      end
      return;
    end
    v = {acc_sum[55:0], it.data_byte[6:0]};
    if (it.data_byte[7]) begin
      acc_sum = v;
      return;
    end
    acc_sum = '0;
    if (!first_split_done) begin
      // first subidentifier carries two arcs
      if (v < 80) begin
        expect_arc(v / 40, 1'b0, 1'b0);
        expect_arc(v % 40, it.end_of_content, 1'b0);
      end else begin
        expect_arc(ArcW'(2), 1'b0, 1'b0);
        expect_arc(v - 80, it.end_of_content, 1'b0);
      end
      first_split_done = 1'b1;
    end else begin
      expect_arc(v, it.end_of_content, 1'b0);
    end
    if (it.end_of_content)
      clear_decode();
  endfunction

  // stimulus builders
  function automatic void push_byte(logic [7:0] d, logic eoc);
    byte_q.push_back(byte_item_t'{data_byte: d, end_of_content: eoc});
    bytes_queued++;
  endfunction

  function automatic int pad_count();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  function automatic logic [ArcW-1:0] rand_arc();
    logic [63:0] r;
    int w;
    w = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 20);
    r = {$urandom, $urandom};
    r = r & ((64'd1 << w) - 64'd1);
    return r[ArcW-1:0];
  endfunction

  // emit one subidentifier base-128, big-endian, with optional 0x80 padding
  function automatic void queue_subid(logic [ArcW-1:0] val, int pad, logic fin);
    int ng;
    logic [ArcW-1:0] t;
    ng = 1;
    t = val >> 7;
    while (t != 0) begin
      ng++;
      t = t >> 7;
    end
    repeat (pad) push_byte(8'h80, 1'b0);
    for (int g = ng - 1; g >= 0; g--)
      push_byte({g != 0, 7'(val >> (7 * g))}, fin && g == 0);
  endfunction

  // well-formed identifier, or one cut off inside its last subidentifier
  function automatic void queue_oid(int n_later, logic cut);
    logic [ArcW-1:0] lead;
    lead = ($urandom_range(0, 2) == 0) ? rand_arc() : ArcW'($urandom_range(0, 119));
    queue_subid(lead, pad_count(), !cut && n_later == 0);
    for (int k = 1; k <= n_later; k++)
      queue_subid(rand_arc(), pad_count(), !cut && k == n_later);
    if (cut)
      push_byte({1'b1, 7'($urandom)}, 1'b1);
  endfunction

  initial begin
    int pick;
    int n;
    // single zero byte
    push_byte(8'h00, 1'b1);
    // padded first subidentifier 79, then 80
    push_byte(8'h80, 1'b0);
    push_byte(8'h4f, 1'b0);
    push_byte(8'h50, 1'b1);
    // first subidentifier 80, then the largest arc
    push_byte(8'h50, 1'b0);
    repeat (8) push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b1);
    // content ends inside a subidentifier
    push_byte(8'h81, 1'b1);
    // overflow mid-content, rest skipped to the end mark
    push_byte(8'h81, 1'b0);
    repeat (8) push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // pause the sender until every arc of the directed part is in
    while (byte_q.size() != 0 || byte_valid || arc_expect_q.size() != 0)
      @(negedge clk);

    while (bytes_queued < TotalBytes) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        queue_oid($urandom_range(0, 5), 1'b0);
      end else if (pick == 7) begin
        queue_oid($urandom_range(0, 3), 1'b1);
      end else if (pick == 8) begin
        // subidentifier that runs past 63 bits
        if ($urandom_range(0, 1))
          queue_subid(ArcW'($urandom_range(0, 119)), 0, 1'b0);
        push_byte({1'b1, 7'($urandom_range(1, 127))}, 1'b0);
        repeat (8) push_byte({1'b1, 7'($urandom)}, 1'b0);
        n = $urandom_range(0, 3);
        push_byte(8'($urandom), n == 0);
        for (int k = 1; k <= n; k++)
          push_byte(8'($urandom), k == n);
      end else begin
        // raw noise, closed by an end mark
        n = $urandom_range(1, 6);
        for (int k = 1; k <= n; k++)
          push_byte(8'($urandom), k == n || $urandom_range(0, 3) == 0);
      end
    end

    // final stretch runs without idling
    while (byte_q.size() > 80)
      @(posedge clk);
    quiet <= 1'b1;

    while (byte_q.size() != 0 || byte_valid || arc_expect_q.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** oid_base128_arc_decoder: PASSED **");
    end else begin
      $display("** oid_base128_arc_decoder: FAILED **");
    end
    $finish;
  end

  // byte driver: hold a stalled transfer, otherwise idle or present the next byte
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      send_gap <= 0;
    end else if (!byte_valid || !byte_stall) begin
      if (send_gap != 0) begin
        byte_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        byte_valid <= 1'b0;
        send_gap <= $urandom_range(0, 7);
      end else if (byte_q.size() != 0) begin
        byte_valid <= 1'b1;
        byte_item <= byte_q.pop_front();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // arc receiver stall: random bursts, plus one long hold-off once enough arcs are seen
  always @(posedge clk) begin
    if (rst) begin
      arc_stall <= 1'b0;
      stall_left <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && arcs_seen >= HoldAfterArcs) begin
      arc_stall <= 1'b1;
      stall_left <= LongHold;
      long_hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      arc_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      arc_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      arc_stall <= 1'b0;
    end
  end

  // monitor: predict on each byte transfer, then check each arc transfer
  always @(posedge clk) begin
    arc_item_t want;
    if (!rst) begin
      if (byte_valid && !byte_stall)
        decode_byte(byte_item);
      if (arc_valid && !arc_stall) begin
        arcs_seen <= arcs_seen + 1;
        if (arc_expect_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected arc: arc=%0d last=%0b err=%0b",
                     arc_item.arc_value, arc_item.last_arc, arc_item.error);
          mismatches++;
        end else begin
          want = arc_expect_q.pop_front();
          if (arc_item.arc_value !== want.arc_value || arc_item.last_arc !== want.last_arc ||
              arc_item.error !== want.error) begin
            if (mismatches < 10)
              $display("arc mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                       want.arc_value, want.last_arc, want.error,
                       arc_item.arc_value, arc_item.last_arc, arc_item.error);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (arc_valid && !arc_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("** oid_base128_arc_decoder: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[filelist.f]
sv/oidd_pkg.sv
sv/oidd_front.sv
sv/oidd_queue.sv
sv/oidd_back.sv
sv/oid_base128_arc_decoder.sv
sv/oidd_checker.sv
verif/tb.sv
